### rtl/uudecode_stream_defines.svh
// Assertion macros used by the top-level RTL.
`ifndef UUDECODE_STREAM_DEFINES_SVH
`define UUDECODE_STREAM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uudecode_stream: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define UDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uudecode_stream: next-cycle check failed");

`endif

### rtl/uds_pkg.sv
`default_nettype none

package uds_pkg;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [7:0] in_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
   } item_type;

   // all results of one request
   typedef struct packed {
      logic [2:0]                       count;
      item_type [MAX_RESULTS-1:0]       item;
   } bundle_type;

endpackage

`default_nettype wire

### rtl/uds_front.sv
`default_nettype none

module uds_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire uds_pkg::req_type   req,
   output uds_pkg::bundle_type     bundle,
   output logic                    bundle_valid
);

   localparam logic [3:0] PH_SEARCH      = 4'd0;
   localparam logic [3:0] PH_SEARCH_SKIP = 4'd1;
   localparam logic [3:0] PH_MODE        = 4'd2;
   localparam logic [3:0] PH_SPACES      = 4'd3;
   localparam logic [3:0] PH_NAME        = 4'd4;
   localparam logic [3:0] PH_CRLF        = 4'd5;
   localparam logic [3:0] PH_LINE_START  = 4'd6;
   localparam logic [3:0] PH_DATA_SKIP   = 4'd7;
   localparam logic [3:0] PH_GROUP       = 4'd8;
   localparam logic [3:0] PH_DONE        = 4'd9;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TICK  = 8'h60;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   localparam logic [2:0] MATCH_LEN = 3'd6;

   function automatic logic [7:0] begin_char(input logic [2:0] pos);
      logic [7:0] pat;
      unique case (pos)
         3'd0:    pat = 8'h62;
         3'd1:    pat = 8'h65;
         3'd2:    pat = 8'h67;
         3'd3:    pat = 8'h69;
         3'd4:    pat = 8'h6E;
         3'd5:    pat = 8'h20;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   function automatic logic [5:0] dec6(input logic [7:0] code);
      return 6'(code[5:0] - 6'd32);
   endfunction

   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  match_pos_ff, match_pos_in;
   logic [5:0]  remain_ff, remain_in;
   logic [1:0]  group_pos_ff, group_pos_in;
   logic [17:0] group_chars_ff, group_chars_in;
   logic        end_cand_ff, end_cand_in;

   logic [7:0]  ch;
   logic [5:0]  d6;
   logic        is_digit;
   logic        is_eol;
   logic        name_go;
   logic        line_go;
   logic        finished_now;
   logic [2:0]  n;
   logic [5:0]  c0, c1, c2;

   assign ch       = req.in_char;
   assign d6       = dec6(req.in_char);
   assign is_digit = (req.in_char >= CH_0) && (req.in_char <= CH_9);
   assign is_eol   = (req.in_char == CH_LF) || (req.in_char == CH_CR);
   assign c0       = group_chars_ff[17:12];
   assign c1       = group_chars_ff[11:6];
   assign c2       = group_chars_ff[5:0];

   always_comb begin
      phase_in       = phase_ff;
      match_pos_in   = match_pos_ff;
      remain_in      = remain_ff;
      group_pos_in   = group_pos_ff;
      group_chars_in = group_chars_ff;
      end_cand_in    = end_cand_ff;
      name_go        = 1'b0;
      line_go        = 1'b0;
      finished_now   = 1'b0;
      n              = 3'd0;
      bundle.item    = '0;

      unique case (phase_ff)
         PH_SEARCH: begin
            if (match_pos_ff < MATCH_LEN && ch == begin_char(match_pos_ff)) begin
               match_pos_in = 3'(match_pos_ff + 3'd1);
            end else if (match_pos_ff == MATCH_LEN && is_digit) begin
               match_pos_in = 3'd0;
               phase_in     = PH_MODE;
            end else begin
               match_pos_in = 3'd0;
               phase_in     = (ch == CH_LF) ? PH_SEARCH : PH_SEARCH_SKIP;
            end
         end
         PH_SEARCH_SKIP: begin
            if (ch == CH_LF) begin
               phase_in = PH_SEARCH;
            end
         end
         PH_MODE: begin
            if (!is_digit) begin
               if (ch == CH_SPACE) begin
                  phase_in = PH_SPACES;
               end else begin
                  name_go = 1'b1;
               end
            end
         end
         PH_SPACES: begin
            name_go = (ch != CH_SPACE);
         end
         PH_NAME: begin
            name_go = 1'b1;
         end
         PH_CRLF: begin
            line_go = !is_eol;
         end
         PH_LINE_START: begin
            line_go = 1'b1;
         end
         PH_DATA_SKIP: begin
            if (ch == CH_LF) begin
               phase_in = PH_LINE_START;
            end
         end
         PH_GROUP: begin
            if (end_cand_ff) begin
               if ((group_pos_ff == 2'd0 && ch == CH_N) ||
                   (group_pos_ff == 2'd1 && ch == CH_D)) begin
                  end_cand_in = 1'b1;
               end else if (group_pos_ff == 2'd2 && (is_eol || ch == CH_NUL)) begin
                  finished_now = 1'b1;
               end else begin
                  end_cand_in = 1'b0;
               end
            end
            if (finished_now) begin
               end_cand_in         = 1'b0;
               phase_in            = PH_DONE;
               bundle.item[0].kind = uds_pkg::KIND_FINISH;
               n                   = 3'd1;
            end else if (group_pos_ff != 2'd3) begin
               group_chars_in = {group_chars_ff[11:0], d6};
               group_pos_in   = 2'(group_pos_ff + 2'd1);
            end else begin
               bundle.item[0].out_byte = {c0, c1[5:4]};
               bundle.item[0].kind     = uds_pkg::KIND_DATA;
               n                       = 3'd1;
               if (remain_ff >= 6'd2) begin
                  bundle.item[1].out_byte = {c1[3:0], c2[5:2]};
                  bundle.item[1].kind     = uds_pkg::KIND_DATA;
                  n                       = 3'd2;
               end
               if (remain_ff >= 6'd3) begin
                  bundle.item[2].out_byte = {c2[1:0], d6};
                  bundle.item[2].kind     = uds_pkg::KIND_DATA;
                  n                       = 3'd3;
               end
               remain_in      = (remain_ff > 6'd3) ? 6'(remain_ff - 6'd3) : 6'd0;
               group_pos_in   = 2'd0;
               group_chars_in = '0;
               end_cand_in    = 1'b0;
               if (remain_ff <= 6'd3) begin
                  phase_in = PH_DATA_SKIP;
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (name_go) begin
         if (is_eol) begin
            phase_in = PH_CRLF;
         end else begin
            phase_in                = PH_NAME;
            bundle.item[0].out_byte = ch;
            bundle.item[0].kind     = uds_pkg::KIND_NAME;
            n                       = 3'd1;
         end
      end

      if (line_go) begin
         if (ch == CH_TICK || ch == CH_CR) begin
            phase_in = PH_DATA_SKIP;
         end else if (ch == CH_LF) begin
            phase_in = PH_LINE_START;
         end else begin
            group_pos_in   = 2'd0;
            group_chars_in = '0;
            if (d6 == 6'd0) begin
               phase_in    = PH_DATA_SKIP;
               end_cand_in = 1'b0;
            end else begin
               remain_in   = d6;
               phase_in    = PH_GROUP;
               end_cand_in = (ch == CH_E);
            end
         end
      end

      if (req.last_char) begin
         if (phase_ff != PH_DONE && !finished_now) begin
            bundle.item[n[1:0]].out_byte = 8'd0;
            bundle.item[n[1:0]].kind     = uds_pkg::KIND_FINISH;
            n                            = 3'(n + 3'd1);
         end
         phase_in       = PH_SEARCH;
         match_pos_in   = 3'd0;
         remain_in      = 6'd0;
         group_pos_in   = 2'd0;
         group_chars_in = '0;
         end_cand_in    = 1'b0;
      end

      bundle.count = n;
      bundle_valid = accept && (n != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SEARCH;
         match_pos_ff   <= 3'd0;
         remain_ff      <= 6'd0;
         group_pos_ff   <= 2'd0;
         group_chars_ff <= '0;
         end_cand_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         match_pos_ff   <= match_pos_in;
         remain_ff      <= remain_in;
         group_pos_ff   <= group_pos_in;
         group_chars_ff <= group_chars_in;
         end_cand_ff    <= end_cand_in;
      end
   end

endmodule

`default_nettype wire

### rtl/uds_queue.sv
`default_nettype none

module uds_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire uds_pkg::bundle_type  wr_data,
   output logic                      full,
   input  wire logic                 rd_en,
   output uds_pkg::bundle_type       rd_data,
   output logic                      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   uds_pkg::bundle_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_rd && !do_wr) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/uds_back.sv
`default_nettype none

module uds_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire uds_pkg::bundle_type  head,
   input  wire logic                 head_empty,
   output logic                      head_pop,
   output uds_pkg::rsp_type          rsp,
   input  wire logic                 rsp_pop
);

   logic [1:0] idx_ff, idx_in;
   logic       at_last;
   logic       take;

   assign at_last      = (3'({1'b0, idx_ff} + 3'd1) == head.count);
   assign take         = rsp_pop && !head_empty;
   assign head_pop     = take && at_last;
   assign rsp.out_byte = head.item[idx_ff].out_byte;
   assign rsp.kind     = head.item[idx_ff].kind;
   assign rsp.last     = at_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = at_last ? 2'd0 : 2'(idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

### rtl/uudecode_stream.sv
// Front decoder is combinational; the queue registers results for the rsp ports.
// Throughput: one request per cycle while the queue is not full; results leave one
// per cycle as rsp_pop takes them; a QUEUE_DEPTH-entry queue absorbs requests.
// The input side stalls only when that queue is full.
// Reset (synchronous): decoder back to begin-line search, queue emptied.
`default_nettype none
`include "uudecode_stream_defines.svh"

module uudecode_stream #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire uds_pkg::req_type  req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output uds_pkg::rsp_type       rsp_data
);

   logic                accept;
   logic                bundle_valid;
   uds_pkg::bundle_type bundle;
   uds_pkg::bundle_type head;
   logic                head_pop;
   logic                rsp_finish;
   logic                rsp_more;

   assign accept     = req_push && !req_full;
   assign rsp_finish = !rsp_empty && (rsp_data.kind == uds_pkg::KIND_FINISH);
   assign rsp_more   = !rsp_empty && rsp_pop && !rsp_data.last;

   uds_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_data),
      .bundle       (bundle),
      .bundle_valid (bundle_valid)
   );

   uds_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_valid),
      .wr_data (bundle),
      .full    (req_full),
      .rd_en   (head_pop),
      .rd_data (head),
      .empty   (rsp_empty)
   );

   uds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (rsp_empty),
      .head_pop   (head_pop),
      .rsp        (rsp_data),
      .rsp_pop    (rsp_pop)
   );

   `UDS_ASSERT_NOW(a_bundle_bound, clock, reset, bundle_valid, bundle.count <= 3'd4)
   `UDS_ASSERT_NOW(a_finish_zero, clock, reset, rsp_finish, rsp_data.out_byte == 8'd0)
   `UDS_ASSERT_NEXT(a_rest_of_request, clock, reset, rsp_more, !rsp_empty)

endmodule

`default_nettype wire
